// ===== rtl/core/kl_pkg.sv =====
// kl_pkg: shared types, codes and constants for the keypad lock.
// Used by kl_entry, kl_ctrl and keypad_lock_with_lockout; depends on nothing.
package kl_pkg;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_KEY  = 2'd1,
    CMD_ECHO = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_DIGIT     = 4'd1,
    EV_BACK      = 4'd2,
    EV_CLEAR     = 4'd3,
    EV_EMPTY     = 4'd4,
    EV_GRANTED   = 4'd5,
    EV_DENIED    = 4'd6,
    EV_LOCKOUT   = 4'd7,
    EV_LOCK_END  = 4'd8,
    EV_AUTH_OPEN = 4'd9,
    EV_INTRUSION = 4'd10,
    EV_CLOSED    = 4'd11,
    EV_IGNORED   = 4'd12
  } event_t;

  typedef enum logic [1:0] {
    ENT_HOLD  = 2'd0,
    ENT_PUSH  = 2'd1,
    ENT_POP   = 2'd2,
    ENT_CLEAR = 2'd3
  } ent_op_t;

  localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [3:0] KEY_BACK       = 4'd10;
  localparam logic [3:0] KEY_SUBMIT     = 4'd11;
  localparam logic [3:0] KEY_CLEAR      = 4'd15;

  localparam logic [3:0] FAIL_MAX = 4'd15;

  localparam logic [2:0] REG_CODE_DIGITS   = 3'd0;
  localparam logic [2:0] REG_CODE_LENGTH   = 3'd1;
  localparam logic [2:0] REG_MAX_FAILURES  = 3'd2;
  localparam logic [2:0] REG_LOCKOUT_MS    = 3'd3;
  localparam logic [2:0] REG_GRANT_MS      = 3'd4;
  localparam logic [2:0] REG_SAMPLE_GAP_MS = 3'd5;
  localparam logic [2:0] REG_OPEN_LIMIT_US = 3'd6;

  localparam logic [31:0] RST_CODE_DIGITS   = 32'h0000_1234;
  localparam logic [3:0]  RST_CODE_LENGTH   = 4'd4;
  localparam logic [3:0]  RST_MAX_FAILURES  = 4'd3;
  localparam logic [15:0] RST_LOCKOUT_MS    = 16'd30000;
  localparam logic [15:0] RST_GRANT_MS      = 16'd10000;
  localparam logic [15:0] RST_SAMPLE_GAP_MS = 16'd300;
  localparam logic [14:0] RST_OPEN_LIMIT_US = 15'd583;

  localparam int CODE_NIBBLES_MAX = 8;

  // ceil(ms / 1000) as floor((ms + 999) * SEC_RECIP >> SEC_SHIFT), exact for 17-bit sums
  localparam logic [16:0] SEC_ROUND = 17'd999;
  localparam logic [17:0] SEC_RECIP = 18'd134218;
  localparam int          SEC_SHIFT = 27;

  typedef struct packed {
    logic [31:0] code_digits;
    logic [3:0]  code_length;
    logic [3:0]  max_failures;
    logic [15:0] lockout_ms;
    logic [15:0] grant_ms;
    logic [15:0] sample_gap_ms;
    logic [14:0] open_limit_us;
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic match;
  } ent_stat_t;

  typedef struct packed {
    event_t      event_code;
    logic [3:0]  failures;
    logic [15:0] lockout_left;
    logic        authorized;
    logic        alert;
    logic        door_open;
  } lock_stat_t;

endpackage

// ===== rtl/core/kl_entry.sv =====
// kl_entry: packed-BCD keypad entry register with push, pop, clear and code compare.
// Depends on kl_pkg.
module kl_entry #(
  parameter int MAX_DIGITS = 8,
  parameter int CNT_W = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  kl_pkg::ent_op_t       op,
  input  logic [3:0]            digit,
  input  logic [31:0]           code_digits,
  input  logic [3:0]            code_length,
  output kl_pkg::ent_stat_t     stat,
  output logic [CNT_W-1:0]      count_next
);

  localparam int DIG_W = 4 * MAX_DIGITS;
  localparam int CMP_W = (DIG_W > 32) ? DIG_W : 32;

  logic [DIG_W-1:0] digits;
  logic [DIG_W-1:0] digits_next;
  logic [CNT_W-1:0] count;
  logic [31:0]      code_mask;
  logic             len_ok;

  always_comb begin
    code_mask = ~(32'hFFFF_FFFF << {code_length, 2'b00});
    len_ok = (code_length != 4'd0) &&
             (code_length <= 4'(kl_pkg::CODE_NIBBLES_MAX)) &&
             (5'(count) == 5'(code_length));
    stat.empty = (count == '0);
    stat.full  = (count >= CNT_W'(MAX_DIGITS));
    stat.match = len_ok && (CMP_W'(digits) == CMP_W'(code_digits & code_mask));
  end

  always_comb begin
    digits_next = digits;
    count_next  = count;
    case (op)
      kl_pkg::ENT_PUSH: begin
        digits_next = (digits << 4) | DIG_W'(digit);
        count_next  = count + 1'b1;
      end
      kl_pkg::ENT_POP: begin
        if (count != '0) begin
          digits_next = digits >> 4;
          count_next  = count - 1'b1;
        end
      end
      kl_pkg::ENT_CLEAR: begin
        digits_next = '0;
        count_next  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits <= '0;
      count  <= '0;
    end else if (fire) begin
      digits <= digits_next;
      count  <= count_next;
    end
  end

endmodule

// ===== rtl/core/kl_ctrl.sv =====
// kl_ctrl: command decode, failure/lockout/grant/sample timers and door monitor.
// Depends on kl_pkg; drives the entry operation for kl_entry.
module kl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [1:0]          command,
  input  logic [3:0]          key_code,
  input  logic [14:0]         echo_us,
  input  kl_pkg::cfg_t        cfg,
  input  kl_pkg::ent_stat_t   ent,
  output kl_pkg::ent_op_t     ent_op,
  output kl_pkg::lock_stat_t  stat
);

  logic [3:0]  failures;
  logic [15:0] lockout_left;
  logic [15:0] grant_left;
  logic [15:0] sample_wait;
  logic        door_was_open;
  logic        alert_active;

  logic [3:0]  failures_next;
  logic [15:0] lockout_left_next;
  logic [15:0] grant_left_next;
  logic [15:0] sample_wait_next;
  logic        door_was_open_next;
  logic        alert_active_next;
  kl_pkg::event_t ev;
  logic [3:0]  fail_inc;
  logic        open_now;

  always_comb begin
    failures_next      = failures;
    lockout_left_next  = lockout_left;
    grant_left_next    = grant_left;
    sample_wait_next   = sample_wait;
    door_was_open_next = door_was_open;
    alert_active_next  = alert_active;
    ev       = kl_pkg::EV_NONE;
    ent_op   = kl_pkg::ENT_HOLD;
    fail_inc = (failures == kl_pkg::FAIL_MAX) ? failures : failures + 4'd1;
    open_now = (echo_us > cfg.open_limit_us);
    case (kl_pkg::cmd_t'(command))
      kl_pkg::CMD_TICK: begin
        if (grant_left != '0) grant_left_next = grant_left - 16'd1;
        if (sample_wait != '0) sample_wait_next = sample_wait - 16'd1;
        if (lockout_left != '0) begin
          lockout_left_next = lockout_left - 16'd1;
          if (lockout_left == 16'd1) begin
            failures_next = '0;
            ev = kl_pkg::EV_LOCK_END;
          end
        end
      end
      kl_pkg::CMD_KEY: begin
        if (lockout_left != '0) begin
          ev = kl_pkg::EV_IGNORED;
        end else begin
          case (key_code) inside
            [4'd0:kl_pkg::KEY_LAST_DIGIT]: begin
              if (ent.full) begin
                ev = kl_pkg::EV_IGNORED;
              end else begin
                ent_op = kl_pkg::ENT_PUSH;
                ev = kl_pkg::EV_DIGIT;
              end
            end
            kl_pkg::KEY_BACK: begin
              ent_op = kl_pkg::ENT_POP;
              ev = kl_pkg::EV_BACK;
            end
            kl_pkg::KEY_CLEAR: begin
              ent_op = kl_pkg::ENT_CLEAR;
              ev = kl_pkg::EV_CLEAR;
            end
            kl_pkg::KEY_SUBMIT: begin
              if (ent.empty) begin
                ev = kl_pkg::EV_EMPTY;
              end else begin
                ent_op = kl_pkg::ENT_CLEAR;
                if (ent.match) begin
                  failures_next   = '0;
                  grant_left_next = cfg.grant_ms;
                  ev = kl_pkg::EV_GRANTED;
                end else begin
                  failures_next = fail_inc;
                  if (fail_inc >= cfg.max_failures) begin
                    lockout_left_next = cfg.lockout_ms;
                    ev = kl_pkg::EV_LOCKOUT;
                  end else begin
                    ev = kl_pkg::EV_DENIED;
                  end
                end
              end
            end
            default: ev = kl_pkg::EV_IGNORED;
          endcase
        end
      end
      kl_pkg::CMD_ECHO: begin
        if (sample_wait != '0) begin
          ev = kl_pkg::EV_IGNORED;
        end else begin
          sample_wait_next = cfg.sample_gap_ms;
          if (echo_us != '0) begin
            if (open_now && !door_was_open) begin
              if (grant_left != '0) begin
                ev = kl_pkg::EV_AUTH_OPEN;
              end else begin
                alert_active_next = 1'b1;
                ev = kl_pkg::EV_INTRUSION;
              end
            end else if (!open_now && door_was_open) begin
              alert_active_next = 1'b0;
              grant_left_next   = '0;
              ev = kl_pkg::EV_CLOSED;
            end
            door_was_open_next = open_now;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.event_code   = ev;
    stat.failures     = failures_next;
    stat.lockout_left = lockout_left_next;
    stat.authorized   = (grant_left_next != '0);
    stat.alert        = alert_active_next;
    stat.door_open    = door_was_open_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      failures      <= '0;
      lockout_left  <= '0;
      grant_left    <= '0;
      sample_wait   <= '0;
      door_was_open <= 1'b0;
      alert_active  <= 1'b0;
    end else if (fire) begin
      failures      <= failures_next;
      lockout_left  <= lockout_left_next;
      grant_left    <= grant_left_next;
      sample_wait   <= sample_wait_next;
      door_was_open <= door_was_open_next;
      alert_active  <= alert_active_next;
    end
  end

endmodule

// ===== rtl/core/keypad_lock_with_lockout.sv =====
// Keypad combination lock with failure lockout and door-open monitoring. Each item
// (tick, key press or echo sample) gives exactly one result item showing the state
// after it. An item is registered on entry; as it leaves, the lock state updates and
// its result enters the output register in the same cycle, one item per cycle while
// res_stall is low. A full output register with res_stall high holds the pipe; one
// more item is taken into the input register before cmd_stall rises. The user writes
// configuration through cfg_we/cfg_index/cfg_data only while no item is in flight;
// the block does not enforce it. Depends on kl_pkg, kl_entry and kl_ctrl.
module keypad_lock_with_lockout #(
  parameter int MAX_DIGITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  command,
  input  logic [3:0]  key_code,
  input  logic [14:0] echo_us,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [3:0]  event_res,
  output logic [3:0]  entry_length,
  output logic [3:0]  failed_count,
  output logic        locked_out,
  output logic        authorized,
  output logic        alert,
  output logic        door_open,
  output logic [6:0]  seconds_left
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  kl_pkg::cfg_t       cfg;
  kl_pkg::ent_stat_t  ent_stat;
  kl_pkg::ent_op_t    ent_op;
  kl_pkg::lock_stat_t lock_stat;

  logic             s1_valid;
  logic [1:0]       s1_command;
  logic [3:0]       s1_key;
  logic [14:0]      s1_echo;
  logic             advance;
  logic             fire;
  logic             accept;
  logic [CNT_W-1:0] count_next;
  logic [16:0]      round_ms;
  logic [34:0]      sec_prod;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_digits   <= kl_pkg::RST_CODE_DIGITS;
      cfg.code_length   <= kl_pkg::RST_CODE_LENGTH;
      cfg.max_failures  <= kl_pkg::RST_MAX_FAILURES;
      cfg.lockout_ms    <= kl_pkg::RST_LOCKOUT_MS;
      cfg.grant_ms      <= kl_pkg::RST_GRANT_MS;
      cfg.sample_gap_ms <= kl_pkg::RST_SAMPLE_GAP_MS;
      cfg.open_limit_us <= kl_pkg::RST_OPEN_LIMIT_US;
    end else if (cfg_we) begin
      case (cfg_index)
        kl_pkg::REG_CODE_DIGITS:   cfg.code_digits   <= cfg_data;
        kl_pkg::REG_CODE_LENGTH:   cfg.code_length   <= cfg_data[3:0];
        kl_pkg::REG_MAX_FAILURES:  cfg.max_failures  <= cfg_data[3:0];
        kl_pkg::REG_LOCKOUT_MS:    cfg.lockout_ms    <= cfg_data[15:0];
        kl_pkg::REG_GRANT_MS:      cfg.grant_ms      <= cfg_data[15:0];
        kl_pkg::REG_SAMPLE_GAP_MS: cfg.sample_gap_ms <= cfg_data[15:0];
        kl_pkg::REG_OPEN_LIMIT_US: cfg.open_limit_us <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  assign advance   = !res_valid || !res_stall;
  assign fire      = s1_valid && advance;
  assign cmd_stall = s1_valid && !advance;
  assign accept    = cmd_valid && !cmd_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_command <= command;
      s1_key     <= key_code;
      s1_echo    <= echo_us;
    end
  end

  kl_entry #(
    .MAX_DIGITS (MAX_DIGITS),
    .CNT_W      (CNT_W)
  ) u_entry (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .op          (ent_op),
    .digit       (s1_key),
    .code_digits (cfg.code_digits),
    .code_length (cfg.code_length),
    .stat        (ent_stat),
    .count_next  (count_next)
  );

  kl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .command  (s1_command),
    .key_code (s1_key),
    .echo_us  (s1_echo),
    .cfg      (cfg),
    .ent      (ent_stat),
    .ent_op   (ent_op),
    .stat     (lock_stat)
  );

  // ceil(lockout ms / 1000)
  always_comb begin
    round_ms = {1'b0, lock_stat.lockout_left} + kl_pkg::SEC_ROUND;
    sec_prod = 35'(round_ms) * 35'(kl_pkg::SEC_RECIP);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= fire || (res_valid && res_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      event_res    <= lock_stat.event_code;
      entry_length <= 4'(count_next);
      failed_count <= lock_stat.failures;
      locked_out   <= (lock_stat.lockout_left != '0);
      authorized   <= lock_stat.authorized;
      alert        <= lock_stat.alert;
      door_open    <= lock_stat.door_open;
      seconds_left <= 7'(sec_prod >> kl_pkg::SEC_SHIFT);
    end
  end

`ifndef SYNTH
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> res_valid)
    else $error("processed item did not reach the result register");

  a_lock_has_seconds: assert property (@(posedge clk) disable iff (rst)
    res_valid && locked_out |-> seconds_left != 7'd0)
    else $error("lockout active with zero seconds left");

  a_lock_end_clears: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res == kl_pkg::EV_LOCK_END |-> failed_count == 4'd0 && !locked_out)
    else $error("lockout end left failures or lockout set");

  a_lock_ignores_digit: assert property (@(posedge clk) disable iff (rst)
    res_valid && locked_out && event_res == kl_pkg::EV_DIGIT |-> 1'b0)
    else $error("digit taken during lockout");
`endif

endmodule

// ===== bench/tb_keypad_lock_with_lockout.sv =====
// tb_keypad_lock_with_lockout: self-checking bench for the keypad lock with lockout.
// Sends a directed table and then randomized phases of ticks, keys and echo samples,
// with random idling on both sides. Every result item is checked against an in-bench
// lock model. Depends on kl_pkg and keypad_lock_with_lockout.
module tb_keypad_lock_with_lockout;

  localparam int MAX_DIGITS = 8;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [3:0] KEY_A = 4'd12;
  localparam logic [3:0] KEY_B = 4'd13;
  localparam logic [3:0] KEY_C = 4'd14;
  localparam int PHASE_ITEMS = 205;
  localparam int HOLD_AT = 700;
  localparam int HOLD_CYCLES = 80;
  localparam int TIMEOUT = 2000000;
  localparam int N_DIR = 27;

  typedef struct packed {
    kl_pkg::event_t ev;
    logic [3:0] len;
    logic [3:0] fails;
    logic       lock;
    logic       auth;
    logic       alrt;
    logic       door;
    logic [6:0] secs;
  } lock_res_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  key;
    logic [14:0] echo;
    logic        known;
    kl_pkg::event_t ev;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        cmd_valid = 1'b0;
  logic [1:0]  command = '0;
  logic [3:0]  key_code = '0;
  logic [14:0] echo_us = '0;
  logic        res_stall = 1'b0;
  logic        cmd_stall;
  logic        res_valid;
  logic [3:0]  event_res;
  logic [3:0]  entry_length;
  logic [3:0]  failed_count;
  logic        locked_out;
  logic        authorized;
  logic        alert;
  logic        door_open;
  logic [6:0]  seconds_left;

  // lock model state and register mirror
  kl_pkg::cfg_t cfg;
  logic [31:0] ent_digits = '0;
  logic [3:0]  ent_count = '0;
  logic [3:0]  fail_cnt = '0;
  logic [15:0] lock_left = '0;
  logic [15:0] grant_left = '0;
  logic [15:0] wait_left = '0;
  logic        door_st = 1'b0;
  logic        alert_st = 1'b0;

  lock_res_t exp_q[$];
  stim_row_t pend_q[$];
  int n_err = 0;
  int n_acc = 0;
  int hold_left = 0;
  bit held = 1'b0;
  bit quiet = 1'b0;

  stim_row_t dir_rows [N_DIR] = '{
    '{kl_pkg::CMD_TICK, 4'd0,               15'd0,     1'b1, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_KEY,  kl_pkg::KEY_SUBMIT, 15'd0,     1'b1, kl_pkg::EV_EMPTY},
    '{kl_pkg::CMD_KEY,  kl_pkg::KEY_BACK,   15'd0,     1'b1, kl_pkg::EV_BACK},
    '{kl_pkg::CMD_KEY,  KEY_A,              15'd0,     1'b1, kl_pkg::EV_IGNORED},
    '{CMD_SPARE,        kl_pkg::KEY_CLEAR,  15'h7FFF,  1'b1, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_KEY,  4'd1,               15'd0,     1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_KEY,  4'd2,               15'd0,     1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_KEY,  4'd3,               15'd0,     1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_KEY,  4'd4,               15'd0,     1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_KEY,  kl_pkg::KEY_SUBMIT, 15'd0,     1'b1, kl_pkg::EV_GRANTED},
    '{kl_pkg::CMD_ECHO, 4'd0,               15'd30000, 1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_ECHO, 4'd0,               15'd100,   1'b1, kl_pkg::EV_IGNORED},
    '{kl_pkg::CMD_TICK, 4'd0,               15'd0,     1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_ECHO, 4'd0,               15'd583,   1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_TICK, 4'd0,               15'd0,     1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_ECHO, 4'd0,               15'd0,     1'b1, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_TICK, 4'd0,               15'd0,     1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_ECHO, 4'd0,               15'd584,   1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_KEY,  4'd9,               15'd0,     1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_KEY,  kl_pkg::KEY_CLEAR,  15'd0,     1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_KEY,  4'd0,               15'd0,     1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_KEY,  kl_pkg::KEY_SUBMIT, 15'd0,     1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_KEY,  4'd8,               15'd0,     1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_KEY,  kl_pkg::KEY_SUBMIT, 15'd0,     1'b1, kl_pkg::EV_LOCKOUT},
    '{kl_pkg::CMD_KEY,  KEY_B,              15'd0,     1'b1, kl_pkg::EV_IGNORED},
    '{kl_pkg::CMD_TICK, 4'd0,               15'd0,     1'b0, kl_pkg::EV_NONE},
    '{kl_pkg::CMD_TICK, 4'd0,               15'd0,     1'b1, kl_pkg::EV_LOCK_END}
  };

  keypad_lock_with_lockout #(.MAX_DIGITS(MAX_DIGITS)) u_dut (.*);

  always #2 clk = ~clk;

  initial begin
    #(TIMEOUT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic lock_step(input logic [1:0] c, input logic [3:0] k, input logic [14:0] e,
                           output lock_res_t r);
    kl_pkg::event_t ev;
    logic [63:0] mask;
    logic open;
    ev = kl_pkg::EV_NONE;
    if (c == kl_pkg::CMD_TICK) begin
      if (grant_left != 0) grant_left = grant_left - 1'b1;
      if (wait_left != 0) wait_left = wait_left - 1'b1;
      if (lock_left != 0) begin
        lock_left = lock_left - 1'b1;
        if (lock_left == 0) begin
          fail_cnt = '0;
          ev = kl_pkg::EV_LOCK_END;
        end
      end
    end else if (c == kl_pkg::CMD_KEY) begin
      if (lock_left != 0) begin
        ev = kl_pkg::EV_IGNORED;
      end else if (k <= kl_pkg::KEY_LAST_DIGIT) begin
        if (ent_count >= MAX_DIGITS) begin
          ev = kl_pkg::EV_IGNORED;
        end else begin
          ent_digits = {ent_digits[27:0], k};
          ent_count = ent_count + 1'b1;
          ev = kl_pkg::EV_DIGIT;
        end
      end else if (k == kl_pkg::KEY_BACK) begin
        if (ent_count != 0) begin
          ent_digits = ent_digits >> 4;
          ent_count = ent_count - 1'b1;
        end
        ev = kl_pkg::EV_BACK;
      end else if (k == kl_pkg::KEY_CLEAR) begin
        ent_digits = '0;
        ent_count = '0;
        ev = kl_pkg::EV_CLEAR;
      end else if (k == kl_pkg::KEY_SUBMIT) begin
        if (ent_count == 0) begin
          ev = kl_pkg::EV_EMPTY;
        end else begin
          mask = (64'd1 << (4 * cfg.code_length)) - 64'd1;
          if (cfg.code_length != 0 && cfg.code_length <= kl_pkg::CODE_NIBBLES_MAX &&
              ent_count == cfg.code_length &&
              {32'd0, ent_digits} == ({32'd0, cfg.code_digits} & mask)) begin
            fail_cnt = '0;
            grant_left = cfg.grant_ms;
            ev = kl_pkg::EV_GRANTED;
          end else begin
            if (fail_cnt != kl_pkg::FAIL_MAX) fail_cnt = fail_cnt + 1'b1;
            if (fail_cnt >= cfg.max_failures) begin
              lock_left = cfg.lockout_ms;
              ev = kl_pkg::EV_LOCKOUT;
            end else begin
              ev = kl_pkg::EV_DENIED;
            end
          end
          ent_digits = '0;
          ent_count = '0;
        end
      end else begin
        ev = kl_pkg::EV_IGNORED;
      end
    end else if (c == kl_pkg::CMD_ECHO) begin
      if (wait_left != 0) begin
        ev = kl_pkg::EV_IGNORED;
      end else begin
        wait_left = cfg.sample_gap_ms;
        if (e != 0) begin
          open = e > cfg.open_limit_us;
          if (open && !door_st) begin
            if (grant_left != 0) begin
              ev = kl_pkg::EV_AUTH_OPEN;
            end else begin
              alert_st = 1'b1;
              ev = kl_pkg::EV_INTRUSION;
            end
          end else if (!open && door_st) begin
            alert_st = 1'b0;
            grant_left = '0;
            ev = kl_pkg::EV_CLOSED;
          end
          door_st = open;
        end
      end
    end
    r.ev = ev;
    r.len = ent_count;
    r.fails = fail_cnt;
    r.lock = lock_left != 0;
    r.auth = grant_left != 0;
    r.alrt = alert_st;
    r.door = door_st;
    r.secs = 7'((int'(lock_left) + 999) / 1000);
  endtask

  task automatic send_item(input stim_row_t it);
    lock_res_t r;
    while (!quiet && $urandom_range(99) < 26) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command <= it.cmd;
    key_code <= it.key;
    echo_us <= it.echo;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    lock_step(it.cmd, it.key, it.echo, r);
    if (it.known) r.ev = it.ev;
    exp_q.push_back(r);
    n_acc++;
  endtask

  task automatic settle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_cfg(input kl_pkg::cfg_t c);
    write_reg(kl_pkg::REG_CODE_DIGITS, c.code_digits);
    write_reg(kl_pkg::REG_CODE_LENGTH, {28'd0, c.code_length});
    write_reg(kl_pkg::REG_MAX_FAILURES, {28'd0, c.max_failures});
    write_reg(kl_pkg::REG_LOCKOUT_MS, {16'd0, c.lockout_ms});
    write_reg(kl_pkg::REG_GRANT_MS, {16'd0, c.grant_ms});
    write_reg(kl_pkg::REG_SAMPLE_GAP_MS, {16'd0, c.sample_gap_ms});
    write_reg(kl_pkg::REG_OPEN_LIMIT_US, {17'd0, c.open_limit_us});
    cfg_we <= 1'b0;
    cfg = c;
  endtask

  task automatic queue_item(input logic [1:0] c, input logic [3:0] k, input logic [14:0] e);
    pend_q.push_back(stim_row_t'{c, k, e, 1'b0, kl_pkg::EV_NONE});
  endtask

  function automatic logic [31:0] rand_bcd();
    logic [31:0] v;
    for (int i = 0; i < 8; i++) v[4*i +: 4] = 4'($urandom_range(9));
    return v;
  endfunction

  // one burst: a code entry, a wrong entry, a door sample, a tick run or a noise item
  task automatic plan_burst();
    int pick;
    int n;
    int v;
    logic [3:0] nib;
    pick = $urandom_range(99);
    if (pick < 30) begin
      n = (cfg.code_length == 0 || cfg.code_length > kl_pkg::CODE_NIBBLES_MAX) ?
          $urandom_range(1, 8) : int'(cfg.code_length);
      if ($urandom_range(3) == 0)
        queue_item(kl_pkg::CMD_KEY, kl_pkg::KEY_CLEAR, 15'($urandom));
      for (int i = n - 1; i >= 0; i--) begin
        nib = cfg.code_digits[4*i +: 4];
        queue_item(kl_pkg::CMD_KEY, nib > kl_pkg::KEY_LAST_DIGIT ? nib - 4'd10 : nib,
                   15'($urandom));
        if (i == n - 1 && $urandom_range(4) == 0) begin
          queue_item(kl_pkg::CMD_KEY, 4'($urandom_range(9)), 15'($urandom));
          queue_item(kl_pkg::CMD_KEY, kl_pkg::KEY_BACK, 15'($urandom));
        end
      end
      queue_item(kl_pkg::CMD_KEY, kl_pkg::KEY_SUBMIT, 15'($urandom));
    end else if (pick < 50) begin
      n = $urandom_range(1, 9);
      repeat (n) begin
        if ($urandom_range(9) == 0)
          queue_item(kl_pkg::CMD_KEY, 4'($urandom_range(KEY_C, KEY_A)), 15'($urandom));
        queue_item(kl_pkg::CMD_KEY, 4'($urandom_range(9)), 15'($urandom));
      end
      queue_item(kl_pkg::CMD_KEY, kl_pkg::KEY_SUBMIT, 15'($urandom));
    end else if (pick < 65) begin
      n = cfg.sample_gap_ms > 12 ? 12 : int'(cfg.sample_gap_ms);
      repeat ($urandom_range(n)) queue_item(kl_pkg::CMD_TICK, 4'($urandom), 15'($urandom));
      pick = $urandom_range(99);
      if (pick < 15) v = 0;
      else if (pick < 50) v = $urandom_range(30000);
      else if (pick < 75) v = int'(cfg.open_limit_us) + $urandom_range(40, 1);
      else if (cfg.open_limit_us > 40) v = int'(cfg.open_limit_us) - $urandom_range(40);
      else v = $urandom_range(cfg.open_limit_us);
      if (v > 30000) v = 30000;
      queue_item(kl_pkg::CMD_ECHO, 4'($urandom), 15'(v));
    end else if (pick < 85) begin
      repeat ($urandom_range(50, 1))
        queue_item(kl_pkg::CMD_TICK, 4'($urandom), 15'($urandom));
    end else begin
      queue_item(2'($urandom_range(3)), 4'($urandom), 15'($urandom));
    end
  endtask

  task automatic run_phase(input kl_pkg::cfg_t c, input bit calm);
    int sent;
    settle();
    load_cfg(c);
    quiet = calm;
    sent = 0;
    while (sent < PHASE_ITEMS || pend_q.size() != 0) begin
      if (pend_q.size() == 0) plan_burst();
      send_item(pend_q.pop_front());
      sent++;
    end
    quiet = 1'b0;
  endtask

  task automatic cmp_field(input string fld, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
      n_err++;
    end
  endtask

  always @(posedge clk) begin
    lock_res_t e;
    if (!rst && res_valid && !res_stall) begin
      if (exp_q.size() == 0) begin
        $display("%0t: result item with none expected, event %0d", $time, event_res);
        n_err++;
      end else begin
        e = exp_q.pop_front();
        cmp_field("event_res", e.ev, event_res);
        cmp_field("entry_length", e.len, entry_length);
        cmp_field("failed_count", e.fails, failed_count);
        cmp_field("locked_out", e.lock, locked_out);
        cmp_field("authorized", e.auth, authorized);
        cmp_field("alert", e.alrt, alert);
        cmp_field("door_open", e.door, door_open);
        cmp_field("seconds_left", e.secs, seconds_left);
      end
    end
  end

  // result side: random stall, one long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!held && n_acc >= HOLD_AT) begin
      res_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      held <= 1'b1;
    end else begin
      res_stall <= !quiet && ($urandom_range(99) < 26);
    end
  end

  initial begin
    kl_pkg::cfg_t c;
    cfg = '{kl_pkg::RST_CODE_DIGITS, kl_pkg::RST_CODE_LENGTH, kl_pkg::RST_MAX_FAILURES,
            kl_pkg::RST_LOCKOUT_MS, kl_pkg::RST_GRANT_MS, kl_pkg::RST_SAMPLE_GAP_MS,
            kl_pkg::RST_OPEN_LIMIT_US};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    c = cfg;
    c.max_failures = 4'd2;
    c.lockout_ms = 16'd2;
    c.sample_gap_ms = 16'd1;
    load_cfg(c);
    foreach (dir_rows[i]) send_item(dir_rows[i]);

    c = '{rand_bcd(), 4'd1, 4'd1, 16'd1, 16'd1, 16'd0, 15'd0};
    run_phase(c, 1'b0);
    c = '{32'h0000_0000, 4'd8, 4'd15, 16'd20, 16'd65535, 16'd3, 15'd30000};
    run_phase(c, 1'b0);
    // code length zero never matches; zero lockout length and zero max failures
    c = '{rand_bcd(), 4'd0, 4'd0, 16'd0, 16'd30, 16'd5, 15'd583};
    run_phase(c, 1'b0);
    c = '{32'hFFFF_FFFF, 4'd15, 4'd2, 16'd10, 16'd10, 16'd1, 15'd1000};
    run_phase(c, 1'b0);
    c = '{rand_bcd(), 4'($urandom_range(8, 1)), 4'($urandom_range(6, 1)),
          16'($urandom_range(40, 1)), 16'($urandom_range(60, 1)), 16'($urandom_range(8)),
          15'($urandom_range(30000))};
    run_phase(c, 1'b1);
    c = '{rand_bcd(), 4'($urandom_range(8, 1)), 4'($urandom_range(6, 1)),
          16'($urandom_range(40, 1)), 16'($urandom_range(60, 1)), 16'($urandom_range(8)),
          15'($urandom_range(30000))};
    run_phase(c, 1'b0);
    c = '{rand_bcd(), 4'($urandom_range(8, 1)), 4'd3, 16'd65535, 16'd65535, 16'd65535,
          15'd583};
    run_phase(c, 1'b0);

    settle();
    repeat (8) @(posedge clk);
    if (n_err == 0 && exp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
